>>> rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define CMID_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CMID_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/cmid_pkg.sv
// Package: constants, codes and controller/datapath types for the distance cache.
`timescale 1ns / 1ps
package cmid_pkg;

   localparam int CMID_MAX_PARTICLES = 16;
   localparam int CMID_DIMS          = 3;

   localparam int MODE_W  = 2;
   localparam int PART_W  = 4;
   localparam int AXIS_W  = 2;
   localparam int COORD_W = 32;
   localparam int DIST_W  = 32;
   localparam int BOX_W   = 31;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 31;
   localparam int ITER_W  = 5;

   localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INVAL  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PROBE  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_TRACKING = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX      = 1'd1;

   localparam logic [1:0] DSEL_HOLD  = 2'd0;
   localparam logic [1:0] DSEL_ZERO  = 2'd1;
   localparam logic [1:0] DSEL_CACHE = 2'd2;
   localparam logic [1:0] DSEL_CALC  = 2'd3;

   typedef struct packed {
      logic       load;
      logic       sel_b;
      logic       cap_a;
      logic       diff;
      logic       div_step;
      logic       fold;
      logic       sq;
      logic       sum_clr;
      logic       acc;
      logic       sqrt_init;
      logic       sqrt_step;
      logic [1:0] dist_sel;
      logic       cache_wr;
      logic       wr_ba;
      logic       out_load;
   } cmid_cmd_type;

   typedef struct packed {
      logic                probe_ok;
      logic                track;
      logic                dirty_ab;
      logic                box_zero;
      logic                out_free;
      logic [MODE_W-1:0]   mode;
   } cmid_status_type;

endpackage

>>> rtl/core/cmid_if.sv
// Interfaces: request and response channels of the distance cache.
`timescale 1ns / 1ps
interface cmid_req_if
   import cmid_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [PART_W-1:0]  particle_a;
   logic [PART_W-1:0]  particle_b;
   logic [AXIS_W-1:0]  axis;
   logic signed [COORD_W-1:0] coordinate;

   modport source (output valid, mode, particle_a, particle_b, axis, coordinate,
                   input ready);
   modport sink   (input valid, mode, particle_a, particle_b, axis, coordinate,
                   output ready);
endinterface

interface cmid_rsp_if
   import cmid_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] distance;
   logic              from_cache;

   modport source (output valid, distance, from_cache, input ready);
   modport sink   (input valid, distance, from_cache, output ready);
endinterface

>>> rtl/core/cached_min_image_distance.sv
// Top level: cached minimum-image distance, write/invalidate/probe items.
// Write and invalidate items complete at accept. A cache hit passes through the check and hit states to the output.
// A computed probe reads, subtracts and squares each axis, then takes a square root; while tracking it also writes
// both cache entries. A nonzero box adds a one-bit-per-cycle remainder unit per axis; the square root has 32 steps.
// One item at a time; the next is accepted once the result sits in the output register.
// Synchronous reset clears configuration and marks every pair dirty; memories are not cleared.
`timescale 1ns / 1ps
module cached_min_image_distance
   import cmid_pkg::*;
#(
   parameter int MAX_PARTICLES = CMID_MAX_PARTICLES,
   parameter int DIMS          = CMID_DIMS
) (
   input  logic                  clock,
   input  logic                  reset,
   cmid_req_if.sink              req_chan,
   cmid_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AXW = (DIMS > 1) ? $clog2(DIMS) : 1;

   cmid_cmd_type    cmd;
   cmid_status_type status;
   logic [AXW-1:0]  cmd_axis;

   cmid_ctrl #(.DIMS(DIMS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd),
      .cmd_axis  (cmd_axis)
   );

   cmid_dp #(.MAX_PARTICLES(MAX_PARTICLES), .DIMS(DIMS)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_mode       (req_chan.mode),
      .req_particle_a (req_chan.particle_a),
      .req_particle_b (req_chan.particle_b),
      .req_axis       (req_chan.axis),
      .req_coordinate (req_chan.coordinate),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .cmd_axis       (cmd_axis),
      .status         (status),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_distance   (rsp_chan.distance),
      .rsp_from_cache (rsp_chan.from_cache)
   );

endmodule

>>> rtl/core/cmid_ctrl.sv
// Controller: sequences lookup, per-axis wrap and square, square root and cache update.
`timescale 1ns / 1ps
module cmid_ctrl
   import cmid_pkg::*;
#(
   parameter int DIMS = CMID_DIMS,
   localparam int AXW = (DIMS > 1) ? $clog2(DIMS) : 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  cmid_status_type status,
   output cmid_cmd_type    cmd,
   output logic [AXW-1:0]  cmd_axis
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CHK  = 4'd1;
   localparam logic [3:0] S_HIT  = 4'd2;
   localparam logic [3:0] S_RDA  = 4'd3;
   localparam logic [3:0] S_RDB  = 4'd4;
   localparam logic [3:0] S_DIFF = 4'd5;
   localparam logic [3:0] S_DIV  = 4'd6;
   localparam logic [3:0] S_FOLD = 4'd7;
   localparam logic [3:0] S_SQ   = 4'd8;
   localparam logic [3:0] S_ACC  = 4'd9;
   localparam logic [3:0] S_SQI  = 4'd10;
   localparam logic [3:0] S_SQRT = 4'd11;
   localparam logic [3:0] S_FIN  = 4'd12;
   localparam logic [3:0] S_WRAB = 4'd13;
   localparam logic [3:0] S_WRBA = 4'd14;
   localparam logic [3:0] S_DONE = 4'd15;

   logic [3:0]        state_ff, state_in;
   logic [AXW-1:0]    axis_ff, axis_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;

   assign req_ready = (state_ff == S_IDLE);
   assign cmd_axis  = axis_ff;

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.mode == MODE_PROBE) begin
                  state_in = S_CHK;
               end
            end
         end
         S_CHK: begin
            cmd.sum_clr = 1'b1;
            axis_in     = '0;
            if (!status.probe_ok) begin
               cmd.dist_sel = DSEL_ZERO;
               state_in     = S_DONE;
            end else if (status.track && !status.dirty_ab) begin
               state_in = S_HIT;
            end else begin
               state_in = S_RDA;
            end
         end
         S_HIT: begin
            cmd.dist_sel = DSEL_CACHE;
            state_in     = S_DONE;
         end
         S_RDA: begin
            state_in = S_RDB;
         end
         S_RDB: begin
            cmd.sel_b = 1'b1;
            cmd.cap_a = 1'b1;
            state_in  = S_DIFF;
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            cnt_in   = '0;
            state_in = status.box_zero ? S_SQ : S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            cmd.fold = 1'b1;
            state_in = S_SQ;
         end
         S_SQ: begin
            cmd.sq   = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc = 1'b1;
            if (axis_ff == AXW'(DIMS - 1)) begin
               state_in = S_SQI;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = S_RDA;
            end
         end
         S_SQI: begin
            cmd.sqrt_init = 1'b1;
            cnt_in        = '0;
            state_in      = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.dist_sel = DSEL_CALC;
            state_in     = status.track ? S_WRAB : S_DONE;
         end
         S_WRAB: begin
            cmd.cache_wr = 1'b1;
            state_in     = S_WRBA;
         end
         S_WRBA: begin
            cmd.cache_wr = 1'b1;
            cmd.wr_ba    = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         axis_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

>>> rtl/core/cmid_dp.sv
// Datapath: coordinate and distance memories, dirty marks, divider, squarer, square root.
`timescale 1ns / 1ps
module cmid_dp
   import cmid_pkg::*;
#(
   parameter int MAX_PARTICLES = CMID_MAX_PARTICLES,
   parameter int DIMS          = CMID_DIMS,
   localparam int AXW = (DIMS > 1) ? $clog2(DIMS) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [MODE_W-1:0]         req_mode,
   input  logic [PART_W-1:0]         req_particle_a,
   input  logic [PART_W-1:0]         req_particle_b,
   input  logic [AXIS_W-1:0]         req_axis,
   input  logic signed [COORD_W-1:0] req_coordinate,
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata,
   input  cmid_cmd_type              cmd,
   input  logic [AXW-1:0]            cmd_axis,
   output cmid_status_type           status,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [DIST_W-1:0]         rsp_distance,
   output logic                      rsp_from_cache
);

   localparam int NPOS  = MAX_PARTICLES * DIMS;
   localparam int NPAIR = MAX_PARTICLES * MAX_PARTICLES;
   localparam int PIW   = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int PAW   = (NPOS > 1) ? $clog2(NPOS) : 1;
   localparam int CAW   = (NPAIR > 1) ? $clog2(NPAIR) : 1;

   logic [COORD_W-1:0] pos_mem [NPOS];
   logic [DIST_W-1:0]  cache_mem [NPAIR];
   logic [NPAIR-1:0]   dirty_ff;

   logic               track_ff;
   logic [BOX_W-1:0]   box_ff;
   logic [PART_W-1:0]  a_ff, b_ff;
   logic [COORD_W-1:0] pos_rd_ff, ca_ff;
   logic [DIST_W-1:0]  cache_rd_ff;
   logic [31:0]        mag_ff, rem_ff, gap_ff;
   logic [63:0]        sq_ff, sum_ff, x_ff, res_ff, bit_ff;
   logic               sat_ff;
   logic [DIST_W-1:0]  dist_ff;
   logic               fc_ff;
   logic               rsp_valid_ff;
   logic [DIST_W-1:0]  rsp_dist_ff;
   logic               rsp_fc_ff;

   logic [PIW-1:0] ia, ib, wa;
   logic           wa_ok, wax_ok;
   logic [PAW-1:0] pos_wr_addr, pos_rd_addr;
   logic [CAW-1:0] ab_addr, ba_addr;
   logic [32:0]    diff;
   logic [31:0]    mag;
   logic [31:0]    rem_sh;
   logic [64:0]    acc_sum;
   logic [63:0]    sq_try;

   assign ia = PIW'(a_ff);
   assign ib = PIW'(b_ff);
   assign wa = PIW'(req_particle_a);
   assign wa_ok  = {28'd0, req_particle_a} < 32'(MAX_PARTICLES);
   assign wax_ok = {30'd0, req_axis} < 32'(DIMS);
   assign pos_wr_addr = PAW'(int'(wa) * DIMS + int'(req_axis));
   assign pos_rd_addr = PAW'(int'(cmd.sel_b ? ib : ia) * DIMS + int'(cmd_axis));
   assign ab_addr = CAW'(int'(ia) * MAX_PARTICLES + int'(ib));
   assign ba_addr = CAW'(int'(ib) * MAX_PARTICLES + int'(ia));

   assign status.probe_ok = ({28'd0, a_ff} < 32'(MAX_PARTICLES)) &&
                            ({28'd0, b_ff} < 32'(MAX_PARTICLES));
   assign status.track    = track_ff;
   assign status.dirty_ab = dirty_ff[ab_addr];
   assign status.box_zero = (box_ff == '0);
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.mode     = req_mode;

   assign diff   = {ca_ff[31], ca_ff} - {pos_rd_ff[31], pos_rd_ff};
   assign mag    = diff[32] ? 32'(-diff) : diff[31:0];
   assign rem_sh = {rem_ff[30:0], mag_ff[31]};
   assign acc_sum = {1'b0, sum_ff} + {1'b0, sq_ff};
   assign sq_try  = res_ff + bit_ff;

   // memories
   always_ff @(posedge clock) begin
      if (cmd.load && req_mode == MODE_WRITE && wa_ok && wax_ok) begin
         pos_mem[pos_wr_addr] <= req_coordinate;
      end
      pos_rd_ff <= pos_mem[pos_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.cache_wr) begin
         cache_mem[cmd.wr_ba ? ba_addr : ab_addr] <= dist_ff;
      end
      cache_rd_ff <= cache_mem[ab_addr];
   end

   // configuration and dirty marks
   always_ff @(posedge clock) begin
      if (reset) begin
         track_ff <= 1'b0;
         box_ff   <= '0;
         dirty_ff <= '1;
      end else begin
         if (csr_we) begin
            dirty_ff <= '1;
            case (csr_index)
               CSR_TRACKING: track_ff <= csr_wdata[0];
               CSR_BOX:      box_ff   <= csr_wdata[BOX_W-1:0];
               default:      track_ff <= track_ff;
            endcase
         end else if (cmd.load && req_mode == MODE_INVAL && track_ff && wa_ok) begin
            for (int k = 0; k < MAX_PARTICLES; k++) begin
               dirty_ff[CAW'(int'(wa) * MAX_PARTICLES + k)] <= 1'b1;
               dirty_ff[CAW'(k * MAX_PARTICLES + int'(wa))] <= 1'b1;
            end
         end else if (cmd.cache_wr && !cmd.wr_ba) begin
            dirty_ff[ab_addr] <= 1'b0;
            dirty_ff[ba_addr] <= 1'b0;
         end
      end
   end

   // arithmetic
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff <= req_particle_a;
         b_ff <= req_particle_b;
      end
      if (cmd.cap_a) begin
         ca_ff <= pos_rd_ff;
      end
      if (cmd.diff) begin
         mag_ff <= mag;
         gap_ff <= mag;
         rem_ff <= '0;
      end
      if (cmd.div_step) begin
         mag_ff <= {mag_ff[30:0], 1'b0};
         rem_ff <= (rem_sh >= {1'b0, box_ff}) ? rem_sh - {1'b0, box_ff} : rem_sh;
      end
      if (cmd.fold) begin
         gap_ff <= ({rem_ff, 1'b0} >= {2'b00, box_ff}) ? {1'b0, box_ff} - rem_ff : rem_ff;
      end
      if (cmd.sq) begin
         sq_ff <= gap_ff * gap_ff;
      end
      if (cmd.sum_clr) begin
         sum_ff <= '0;
         sat_ff <= 1'b0;
      end else if (cmd.acc) begin
         sum_ff <= acc_sum[63:0];
         sat_ff <= sat_ff | acc_sum[64];
      end
      if (cmd.sqrt_init) begin
         x_ff   <= sum_ff;
         res_ff <= '0;
         bit_ff <= 64'd1 << 62;
      end else if (cmd.sqrt_step) begin
         if (x_ff >= sq_try) begin
            x_ff   <= x_ff - sq_try;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      case (cmd.dist_sel)
         DSEL_ZERO: begin
            dist_ff <= '0;
            fc_ff   <= 1'b0;
         end
         DSEL_CACHE: begin
            dist_ff <= cache_rd_ff;
            fc_ff   <= 1'b1;
         end
         DSEL_CALC: begin
            dist_ff <= sat_ff ? '1 : res_ff[DIST_W-1:0];
            fc_ff   <= 1'b0;
         end
         default: begin
            dist_ff <= dist_ff;
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_dist_ff <= dist_ff;
         rsp_fc_ff   <= fc_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_distance   = rsp_dist_ff;
   assign rsp_from_cache = rsp_fc_ff;

endmodule

>>> rtl/core/cmid_checker.sv
// Checker: port-level assertions on the distance cache, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cmid_checker
   import cmid_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [MODE_W-1:0] req_mode,
   input logic              rsp_valid,
   input logic              rsp_ready
);

   `CMID_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result item dropped before taken")
   `CMID_ASSERT(a_probe_busy, clock, reset, req_valid && req_ready && req_mode == MODE_PROBE |=> !req_ready, "probe item did not occupy the block")
   `CMID_ASSERT(a_rsp_not_after_accept, clock, reset, $rose(rsp_valid) |-> !$past(req_valid && req_ready), "result appeared straight after an accept")
   `CMID_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind cached_min_image_distance cmid_checker u_cmid_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_mode  (req_chan.mode),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready)
);

>>> dv/cmid_checker.sv
// Checker: watches the distance cache channels, predicts each probe result and compares.
`timescale 1ns / 1ps
module cmid_scoreboard
   import cmid_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [PART_W-1:0]     req_particle_a,
   input  logic [PART_W-1:0]     req_particle_b,
   input  logic [AXIS_W-1:0]     req_axis,
   input  logic [COORD_W-1:0]    req_coordinate,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [DIST_W-1:0]     rsp_distance,
   input  logic                  rsp_from_cache,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending
);
   localparam int NP = CMID_MAX_PARTICLES;
   localparam int ND = CMID_DIMS;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              from_cache;
   } probe_result_type;

   logic             track_on;
   logic [BOX_W-1:0] box_edge;
   logic [31:0]      coords [NP*ND];
   logic [31:0]      dist_store [NP*NP];
   logic             stale [NP*NP];
   probe_result_type expected_q [$];
   int               n_err;

   assign pending = expected_q.size();

   function automatic logic [31:0] int_sqrt(logic [63:0] x);
      logic [63:0] res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > x) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (x >= res + bit_v) begin
            x = x - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res[31:0];
   endfunction

   function automatic logic [31:0] pair_distance(int a, int b);
      logic [64:0] sum;
      logic [63:0] mag, len, q, sq;
      longint      d, r;
      sum = 0;
      for (int ax = 0; ax < ND; ax++) begin
         d = longint'($signed(coords[a*ND+ax])) - longint'($signed(coords[b*ND+ax]));
         mag = (d < 0) ? -d : d;
         if (box_edge != 0) begin
            len = box_edge;
            q = (2*mag + len) / (2*len);
            r = longint'(mag) - longint'(q*len);
            mag = (r < 0) ? -r : r;
         end
         sq = mag * mag;
         sum = sum + sq;
         if (sum[64]) return 32'hFFFF_FFFF;
      end
      return int_sqrt(sum[63:0]);
   endfunction

   task automatic apply_item();
      int a, b;
      probe_result_type res;
      a = req_particle_a;
      b = req_particle_b;
      case (req_mode)
         MODE_WRITE: if (req_axis < ND) coords[a*ND+req_axis] = req_coordinate;
         MODE_INVAL: if (track_on)
            for (int k = 0; k < NP; k++) begin
               stale[a*NP+k] = 1;
               stale[k*NP+a] = 1;
            end
         MODE_PROBE: begin
            res = '0;
            if (!track_on) begin
               res.distance = pair_distance(a, b);
            end else if (stale[a*NP+b]) begin
               res.distance = pair_distance(a, b);
               dist_store[a*NP+b] = res.distance;
               dist_store[b*NP+a] = res.distance;
               stale[a*NP+b] = 0;
               stale[b*NP+a] = 0;
            end else begin
               res.distance = dist_store[a*NP+b];
               res.from_cache = 1;
            end
            expected_q.push_back(res);
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         track_on <= 0;
         box_edge <= 0;
         fail_count <= 0;
         for (int i = 0; i < NP*NP; i++) stale[i] = 1;
         for (int i = 0; i < NP*ND; i++) coords[i] = 0;
         expected_q.delete();
      end else begin
         n_err = 0;
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("unexpected result distance %h", rsp_distance);
               n_err++;
            end else begin
               if (rsp_distance !== expected_q[0].distance) begin
                  $error("distance: expected %h actual %h", expected_q[0].distance,
                         rsp_distance);
                  n_err++;
               end
               if (rsp_from_cache !== expected_q[0].from_cache) begin
                  $error("from_cache: expected %b actual %b", expected_q[0].from_cache,
                         rsp_from_cache);
                  n_err++;
               end
               void'(expected_q.pop_front());
            end
         end
         if (n_err != 0) fail_count <= fail_count + n_err;
         if (req_valid && req_ready) apply_item();
         if (csr_we) begin
            if (csr_index == CSR_TRACKING) track_on <= csr_wdata[0];
            else box_edge <= csr_wdata[BOX_W-1:0];
            for (int i = 0; i < NP*NP; i++) stale[i] = 1;
         end
      end
   end
endmodule

>>> dv/tb.sv
// Testbench top: stimulus, idling and verdict for the cached distance block.
`timescale 1ns / 1ps
module tb;
   import cmid_pkg::*;

   localparam int WATCHDOG = 20000;

   logic clock;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int   fail_count, pending, idle_cycles;
   bit   timed_out;
   logic [15:0] written;

   cmid_req_if req_chan ();
   cmid_rsp_if rsp_chan ();

   cached_min_image_distance DUT (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata));

   cmid_scoreboard checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_chan.valid), .req_ready(req_chan.ready), .req_mode(req_chan.mode),
      .req_particle_a(req_chan.particle_a), .req_particle_b(req_chan.particle_b),
      .req_axis(req_chan.axis), .req_coordinate(req_chan.coordinate),
      .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
      .rsp_distance(rsp_chan.distance), .rsp_from_cache(rsp_chan.from_cache),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending));

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // receiver stalls in runs
   int stall_run;
   initial begin
      rsp_chan.ready = 0;
      stall_run = 0;
      forever begin
         @(negedge clock);
         if (stall_run > 0) begin
            stall_run--;
            rsp_chan.ready <= 0;
         end else if ($urandom_range(0, 9) == 0) begin
            stall_run = $urandom_range(1, 30);
            rsp_chan.ready <= 0;
         end else begin
            rsp_chan.ready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (!reset && idle_cycles >= WATCHDOG && !timed_out) begin
         timed_out = 1;
         $display("FAILURE");
         $finish;
      end
   end

   int burst_left;

   // ready only moves at rising edges, so it is checked at the falling edge before
   task automatic send_item(logic [MODE_W-1:0] m, int a, int b, int ax, logic [31:0] c);
      if (burst_left == 0) begin
         req_chan.valid <= 0;
         repeat ($urandom_range(1, 60)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_chan.valid      <= 1;
      req_chan.mode       <= m;
      req_chan.particle_a <= PART_W'(a);
      req_chan.particle_b <= PART_W'(b);
      req_chan.axis       <= AXIS_W'(ax);
      req_chan.coordinate <= c;
      while (!req_chan.ready) @(negedge clock);
      @(negedge clock);
      if (m == MODE_WRITE && ax < CMID_DIMS && ax == 2) written[a] = 1;
   endtask

   task automatic write_particle(int p, logic [31:0] x, logic [31:0] y, logic [31:0] z);
      send_item(MODE_WRITE, p, 0, 0, x);
      send_item(MODE_WRITE, p, 0, 1, y);
      send_item(MODE_WRITE, p, 0, 2, z);
   endtask

   task automatic drain_and_set(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      req_chan.valid <= 0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 4))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic int rand_written();
      int p;
      do p = $urandom_range(0, 15); while (!written[p]);
      return p;
   endfunction

   task automatic random_phase(int n);
      int r;
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 25) send_item(MODE_WRITE, $urandom_range(0, 15), $urandom_range(0, 15),
                                $urandom_range(0, 3), rand_coord());
         else if (r < 40) send_item(MODE_INVAL, $urandom_range(0, 15),
                                    $urandom_range(0, 15), $urandom_range(0, 3), $urandom);
         else if (r < 43) send_item(MODE_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
                                    $urandom_range(0, 3), $urandom);
         else send_item(MODE_PROBE, rand_written(), rand_written(),
                        $urandom_range(0, 3), $urandom);
      end
   endtask

   initial begin
      reset = 1;
      csr_we = 0; csr_index = 0; csr_wdata = 0;
      req_chan.valid = 0; req_chan.mode = 0; req_chan.particle_a = 0;
      req_chan.particle_b = 0; req_chan.axis = 0; req_chan.coordinate = 0;
      written = 0; burst_left = 0; timed_out = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: extremes, all modes, saturation, same particle, ignored items
      write_particle(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      write_particle(15, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      write_particle(1, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000);
      send_item(MODE_PROBE, 0, 15, 0, 0);
      send_item(MODE_PROBE, 15, 15, 0, 0);
      send_item(MODE_PROBE, 1, 0, 0, 0);
      send_item(MODE_WRITE, 1, 0, 3, 32'h1234_5678);
      send_item(MODE_UNUSED, 15, 15, 3, 32'hFFFF_FFFF);
      send_item(MODE_INVAL, 1, 0, 0, 0);
      send_item(MODE_PROBE, 1, 15, 0, 0);
      drain_and_set(CSR_TRACKING, CSR_DATA_W'(1));
      send_item(MODE_PROBE, 1, 15, 0, 0);
      send_item(MODE_PROBE, 15, 1, 0, 0);
      send_item(MODE_WRITE, 1, 0, 0, 32'h0005_0000);
      send_item(MODE_PROBE, 1, 15, 0, 0);
      send_item(MODE_INVAL, 15, 0, 0, 0);
      send_item(MODE_PROBE, 15, 1, 0, 0);
      send_item(MODE_PROBE, 0, 0, 0, 0);
      drain_and_set(CSR_BOX, 31'h7FFF_FFFF);
      send_item(MODE_PROBE, 0, 15, 0, 0);
      drain_and_set(CSR_BOX, 31'h0001_0000);
      send_item(MODE_PROBE, 0, 1, 0, 0);

      for (int p = 2; p < 15; p++)
         write_particle(p, rand_coord(), rand_coord(), rand_coord());
      random_phase(400);
      drain_and_set(CSR_TRACKING, CSR_DATA_W'(0));
      random_phase(300);
      drain_and_set(CSR_BOX, CSR_DATA_W'(0));
      random_phase(300);
      drain_and_set(CSR_TRACKING, CSR_DATA_W'(1));
      random_phase(300);
      drain_and_set(CSR_BOX, CSR_DATA_W'($urandom_range(1, 32'h0100_0000)));
      random_phase(300);

      req_chan.valid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/cmid_pkg.sv
rtl/core/cmid_if.sv
rtl/core/cmid_ctrl.sv
rtl/core/cmid_dp.sv
rtl/core/cached_min_image_distance.sv
rtl/core/cmid_checker.sv
dv/cmid_checker.sv
dv/tb.sv
